// ===== hdl/wbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared constants, register codes and the types passed to the window matcher.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_PATTERN_DEF   = 32;
  localparam int ADDRESS_WIDTH_DEF = 64;

  // Fixed by the register map: four 64-bit pattern words, 32 wildcard bits.
  localparam int PATTERN_BYTES = 32;
  localparam int LEN_W         = 6;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW      = 3'd0,
    REG_PATTERN_MID_LOW  = 3'd1,
    REG_PATTERN_MID_HIGH = 3'd2,
    REG_PATTERN_HIGH     = 3'd3,
    REG_WILDCARD_MASK    = 3'd4,
    REG_PATTERN_LENGTH   = 3'd5,
    REG_BASE_ADDRESS     = 3'd6,
    REG_SCAN_SIZE        = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PATTERN_BYTES-1:0][7:0] bytes;
    logic [PATTERN_BYTES-1:0]      wild;
    logic [LEN_W-1:0]              length;
  } pattern_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] len_eff;
  } match_res_t;

endpackage

// ===== hdl/wildcard_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner core
// Finds the first place in a byte stream where a wildcard pattern matches.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the in_ channel (valid/stall); one transfer carries one
//   byte and a start flag that opens a new scan. Each byte yields exactly one
//   transfer on the out_ channel with the latched match status, the address
//   of the first match and the scan-done flag.
//   Throughput is one byte per cycle while the receiver does not stall: the
//   window compare and the address add sit in one stage between the input
//   register and the output register. Each byte passes the input register
//   and then the output register before out_valid rises for its result.
//   When the receiver stalls, the output register holds; the input register
//   takes one more byte, then in_stall rises until the output drains.
//   Configuration goes through the APB port (64-bit data, register i at byte
//   address 8*i); write it only while no byte is in flight.
//   Reset clears the scan state, empties both registers and restores the
//   register reset values (pattern length one, all else zero).
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN   = wbps_pkg::MAX_PATTERN_DEF,
  parameter int ADDRESS_WIDTH = wbps_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [5:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  // byte input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_scan_byte,
  input  logic                     in_scan_start,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_match_found,
  output logic [ADDRESS_WIDTH-1:0] out_match_address,
  output logic                     out_scan_done
);
  import wbps_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [3:0][63:0]   pattern_r;
  logic [31:0]        wildcard_r;
  logic [LEN_W-1:0]   length_r;
  logic [63:0]        base_r;
  logic [31:0]        size_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      wildcard_r <= '0;
      length_r   <= LEN_W'(1);
      base_r     <= '0;
      size_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PATTERN_LOW:      pattern_r[0] <= pwdata;
        REG_PATTERN_MID_LOW:  pattern_r[1] <= pwdata;
        REG_PATTERN_MID_HIGH: pattern_r[2] <= pwdata;
        REG_PATTERN_HIGH:     pattern_r[3] <= pwdata;
        REG_WILDCARD_MASK:    wildcard_r   <= pwdata[31:0];
        REG_PATTERN_LENGTH:   length_r     <= pwdata[LEN_W-1:0];
        REG_BASE_ADDRESS:     base_r       <= pwdata;
        REG_SCAN_SIZE:        size_r       <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PATTERN_LOW:      prdata = pattern_r[0];
      REG_PATTERN_MID_LOW:  prdata = pattern_r[1];
      REG_PATTERN_MID_HIGH: prdata = pattern_r[2];
      REG_PATTERN_HIGH:     prdata = pattern_r[3];
      REG_WILDCARD_MASK:    prdata = {32'd0, wildcard_r};
      REG_PATTERN_LENGTH:   prdata = {{(64-LEN_W){1'b0}}, length_r};
      REG_BASE_ADDRESS:     prdata = base_r;
      REG_SCAN_SIZE:        prdata = {32'd0, size_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_start_r;
  logic       in_take;
  logic       a_fire;

  // Process the held byte whenever the output register is free or draining.
  assign a_fire   = a_valid_r && !(out_valid && out_stall);
  assign in_stall = a_valid_r && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r  <= in_scan_byte;
      a_start_r <= in_scan_start;
    end
  end

  // --------------------------------------------------------------------------
  // Scan state and next-state logic
  // --------------------------------------------------------------------------
  logic [MAX_PATTERN-1:0][7:0] window_r;
  logic [31:0]                 seen_r;
  logic                        found_r;
  logic [ADDRESS_WIDTH-1:0]    found_addr_r;

  logic [MAX_PATTERN-1:0][7:0] window_cur;
  logic [MAX_PATTERN-1:0][7:0] window_nxt;
  logic [31:0]                 seen_cur;
  logic [31:0]                 seen_nxt;
  logic                        found_cur;
  logic                        found_nxt;
  logic [ADDRESS_WIDTH-1:0]    found_addr_cur;
  logic [ADDRESS_WIDTH-1:0]    found_addr_nxt;
  logic                        in_range;
  logic                        base_live;
  logic [31:0]                 offset;
  logic [63:0]                 addr_sum;
  pattern_cfg_t                pat_cfg;
  match_res_t                  mres;

  // A start byte sees the cleared state.
  assign window_cur     = a_start_r ? '0 : window_r;
  assign seen_cur       = a_start_r ? '0 : seen_r;
  assign found_cur      = a_start_r ? 1'b0 : found_r;
  assign found_addr_cur = a_start_r ? '0 : found_addr_r;

  assign in_range  = seen_cur < size_r;
  assign base_live = base_r[ADDRESS_WIDTH-1:0] != '0;

  // Shift the window only for bytes inside the scan; newest byte in slot 0.
  always_comb begin
    window_nxt = window_cur;
    if (in_range) begin
      window_nxt[0] = a_byte_r;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        window_nxt[k] = window_cur[k-1];
      end
    end
  end

  assign seen_nxt = in_range ? seen_cur + 32'd1 : seen_cur;

  assign pat_cfg.bytes  = pattern_r;
  assign pat_cfg.wild   = wildcard_r;
  assign pat_cfg.length = length_r;

  wbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .window (window_nxt),
    .pat_cfg(pat_cfg),
    .res    (mres)
  );

  // Start address of the window that just completed the match.
  assign offset   = seen_nxt - {{(32-LEN_W){1'b0}}, mres.len_eff};
  assign addr_sum = base_r + {32'd0, offset};

  always_comb begin
    found_nxt      = found_cur;
    found_addr_nxt = found_addr_cur;
    if (in_range && !found_cur && base_live && mres.hit &&
        seen_nxt >= {{(32-LEN_W){1'b0}}, mres.len_eff}) begin
      found_nxt      = 1'b1;
      found_addr_nxt = addr_sum[ADDRESS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      seen_r       <= '0;
      found_r      <= 1'b0;
      found_addr_r <= '0;
    end else if (a_fire) begin
      window_r     <= window_nxt;
      seen_r       <= seen_nxt;
      found_r      <= found_nxt;
      found_addr_r <= found_addr_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [ADDRESS_WIDTH-1:0] out_addr_r;
  logic                     out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_found_r <= found_nxt;
      out_addr_r  <= found_nxt ? found_addr_nxt : '0;
      out_done_r  <= seen_nxt >= size_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_found   = out_found_r;
  assign out_match_address = out_addr_r;
  assign out_scan_done     = out_done_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && !(a_fire && a_start_r) |=> found_r)
    else $error("latched match dropped without a new scan");

  a_addr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> found_addr_r == '0)
    else $error("match address set without a match");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire |=> out_valid_r)
    else $error("processed byte gave no result");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_fire |=> a_valid_r && $stable(a_byte_r) && $stable(a_start_r))
    else $error("held input byte lost or overwritten");

endmodule

// ===== hdl/wbps_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window matcher
// Compares the byte window against the pattern, aligned so that the last
// pattern byte sits on the newest window byte; wildcard positions always pass.
// ----------------------------------------------------------------------------
module wbps_match #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN-1:0][7:0] window,
  input  wbps_pkg::pattern_cfg_t      pat_cfg,
  output wbps_pkg::match_res_t        res
);
  import wbps_pkg::*;

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W:0]   last_pos;
  logic             mismatch;

  // Saturate the length to the window depth.
  always_comb begin
    if (pat_cfg.length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pat_cfg.length;
    end
  end

  assign last_pos = {1'b0, len_eff} - (LEN_W+1)'(1);

  // Pattern byte i lines up with window slot w where i + w == len - 1.
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      for (int w = 0; w < MAX_PATTERN; w++) begin
        if (((LEN_W+1)'(i) + (LEN_W+1)'(w)) == last_pos && !pat_cfg.wild[i] &&
            window[w] != pat_cfg.bytes[i]) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign res.hit     = (len_eff != '0) && !mismatch;
  assign res.len_eff = len_eff;

endmodule
